FILE: src/pngcs_pkg.sv
// ----------------------------------------------------------------------------
// pngcs_pkg
// Shared types and constants for the PNG chunk structure checker: status
// codes, walk phases, the signature table and the chunk type codes.
// ----------------------------------------------------------------------------
package pngcs_pkg;

  // Status codes reported on the last byte of a file
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_SIG  = 3'd1;
  localparam logic [2:0] ST_NOT_IHDR = 3'd2;
  localparam logic [2:0] ST_TRUNC    = 3'd3;
  localparam logic [2:0] ST_NO_IDAT  = 3'd4;

  // Chunk type codes, big-endian ASCII
  localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
  localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;

  // Bytes of CRC that follow the chunk data
  localparam logic [32:0] CRC_BYTES = 33'd4;

  // Walk phase, one-hot
  typedef enum logic [2:0] {
    PH_SIG  = 3'b001,
    PH_HDR  = 3'b010,
    PH_SKIP = 3'b100
  } phase_t;

  // Expected signature byte at a given position
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h89;
      3'd1:    val = 8'h50;
      3'd2:    val = 8'h4E;
      3'd3:    val = 8'h47;
      3'd4:    val = 8'h0D;
      3'd5:    val = 8'h0A;
      3'd6:    val = 8'h1A;
      default: val = 8'h0A;
    endcase
    return val;
  endfunction

endpackage

FILE: src/png_chunk_structure_checker.sv
// ----------------------------------------------------------------------------
// png_chunk_structure_checker
// Checks the signature and chunk layout of a PNG file streamed in bytewise.
// ----------------------------------------------------------------------------
// The block takes one file byte per cycle while in_stall is low, with is_last
// set on the final byte of each file, and gives exactly one status item per
// file. The last byte is taken into the input register, and its status is
// loaded into the result register when that byte leaves it. Status is
// 0 ok, 1 bad signature, 2 first chunk not IHDR, 3 truncated chunk, 4 no IDAT
// chunk; the first error found is the one reported. Chunk data and CRCs are
// skipped without checking. The throughput of one byte per cycle is set by
// the per-byte walk state update, whose longest path is the 33-bit skip
// counter decrement and zero compare. A stalled status item stalls input
// only once a second last byte reaches the input register.
// ----------------------------------------------------------------------------
module png_chunk_structure_checker
  import pngcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       is_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status
);

  logic       in_reg_valid;
  logic [7:0] in_reg_byte;
  logic       in_reg_last;
  logic       in_accept;
  logic       in_reg_adv;
  logic [2:0] core_status;

  // A byte moves on unless it would produce a status with the slot full
  assign in_reg_adv = in_reg_valid && (!in_reg_last || !out_valid || !out_stall);
  assign in_stall   = in_reg_valid && !in_reg_adv;
  assign in_accept  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_accept) begin
      in_reg_valid <= 1'b1;
    end else if (in_reg_adv) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_reg_byte <= data_byte;
      in_reg_last <= is_last;
    end
  end

  pngcs_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (in_reg_adv),
    .data_byte (in_reg_byte),
    .is_last   (in_reg_last),
    .status    (core_status)
  );

  // Result register: load on a last byte, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_reg_adv && in_reg_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_reg_adv && in_reg_last) begin
      status <= core_status;
    end
  end

endmodule

FILE: src/pngcs_core.sv
// ----------------------------------------------------------------------------
// pngcs_core
// Walk state of the checker: signature match, chunk header capture, body
// skip count and the latched first error. Gives the status of the file as
// it stands after the current byte.
// ----------------------------------------------------------------------------
module pngcs_core
  import pngcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       is_last,
  output logic [2:0] status
);

  phase_t      phase, phase_next;
  logic [2:0]  byte_index, byte_index_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [32:0] skip_remaining, skip_remaining_next;
  logic [31:0] type_shift, type_shift_next;
  logic        first_chunk_pending, first_chunk_pending_next;
  logic        idat_seen, idat_seen_next;
  logic [2:0]  error_code, error_code_next;

  // Advance the walk by one byte
  always_comb begin
    phase_next               = phase;
    byte_index_next          = byte_index;
    chunk_length_next        = chunk_length;
    skip_remaining_next      = skip_remaining;
    type_shift_next          = type_shift;
    first_chunk_pending_next = first_chunk_pending;
    idat_seen_next           = idat_seen;
    error_code_next          = error_code;
    if (error_code == ST_OK) begin
      case (phase)
        PH_SIG: begin
          if (data_byte != sig_byte(byte_index)) begin
            error_code_next = ST_BAD_SIG;
          end else if (byte_index == 3'd7) begin
            phase_next      = PH_HDR;
            byte_index_next = 3'd0;
          end else begin
            byte_index_next = byte_index + 3'd1;
          end
        end
        PH_SKIP: begin
          if (skip_remaining != 33'd0) begin
            skip_remaining_next = skip_remaining - 33'd1;
          end
          if (skip_remaining_next == 33'd0) begin
            phase_next      = PH_HDR;
            byte_index_next = 3'd0;
          end
        end
        default: begin
          // Header phase; the unused code behaves the same
          if (!byte_index[2]) begin
            chunk_length_next = {chunk_length[23:0], data_byte};
          end else begin
            type_shift_next = {type_shift[23:0], data_byte};
          end
          if (byte_index == 3'd7) begin
            if (first_chunk_pending && type_shift_next != TYPE_IHDR) begin
              error_code_next = ST_NOT_IHDR;
            end else begin
              first_chunk_pending_next = 1'b0;
              if (type_shift_next == TYPE_IDAT) begin
                idat_seen_next = 1'b1;
              end
              skip_remaining_next = {1'b0, chunk_length} + CRC_BYTES;
              phase_next          = PH_SKIP;
              byte_index_next     = 3'd0;
            end
          end else begin
            byte_index_next = byte_index + 3'd1;
          end
        end
      endcase
    end
  end

  // Judge the file as it stands after this byte
  always_comb begin
    if (error_code_next != ST_OK) begin
      status = error_code_next;
    end else if (phase_next == PH_SIG) begin
      status = ST_BAD_SIG;
    end else if (phase_next == PH_SKIP) begin
      status = ST_TRUNC;
    end else if (byte_index_next != 3'd0) begin
      status = ST_TRUNC;
    end else if (idat_seen_next) begin
      status = ST_OK;
    end else begin
      status = ST_NO_IDAT;
    end
  end

  // Hold state; restart the walk after the last byte of a file
  always_ff @(posedge clk) begin
    if (rst || (step && is_last)) begin
      phase               <= PH_SIG;
      byte_index          <= 3'd0;
      chunk_length        <= 32'd0;
      skip_remaining      <= 33'd0;
      type_shift          <= 32'd0;
      first_chunk_pending <= 1'b1;
      idat_seen           <= 1'b0;
      error_code          <= ST_OK;
    end else if (step) begin
      phase               <= phase_next;
      byte_index          <= byte_index_next;
      chunk_length        <= chunk_length_next;
      skip_remaining      <= skip_remaining_next;
      type_shift          <= type_shift_next;
      first_chunk_pending <= first_chunk_pending_next;
      idat_seen           <= idat_seen_next;
      error_code          <= error_code_next;
    end
  end

endmodule
